// ===== hdl/pc_pkg.sv =====
// Shared types, constants and helpers for the pressure compensation core.
// No dependencies.
package pc_pkg;

    localparam int RAW_W  = 20;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 8;

    // Register indexes of the configuration port
    localparam logic [ADDR_W-1:0] CFG_P1   = 8'd0;
    localparam logic [ADDR_W-1:0] CFG_P2   = 8'd1;
    localparam logic [ADDR_W-1:0] CFG_P3   = 8'd2;
    localparam logic [ADDR_W-1:0] CFG_P4   = 8'd3;
    localparam logic [ADDR_W-1:0] CFG_P5   = 8'd4;
    localparam logic [ADDR_W-1:0] CFG_P6   = 8'd5;
    localparam logic [ADDR_W-1:0] CFG_P7   = 8'd6;
    localparam logic [ADDR_W-1:0] CFG_P8P9 = 8'd7;

    // Temperature term fixed: v1 = 50000 - 64000, q = v1 >>> 2, q*q = 12250000
    localparam logic [31:0] K_V1     = 32'hFFFF_C950;  // -14000
    localparam logic [31:0] K_V1X2   = 32'hFFFF_92A0;  // -28000
    localparam logic [31:0] K_QQ11   = 32'd5981;       // (q*q) >>> 11
    localparam logic [31:0] K_QQ13   = 32'd1495;       // (q*q) >>> 13
    localparam logic [31:0] K_HALF   = 32'd32768;
    localparam logic [31:0] K_FULL   = 32'd1048576;
    localparam logic [31:0] K_3125   = 32'd3125;

    typedef struct packed {
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [31:0] p89;
    } cal_t;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] dv;
        logic        dbl;
        logic        zero;
    } div_in_t;

    typedef struct packed {
        logic [31:0] quo;
        logic        dbl;
        logic        zero;
    } div_out_t;

    function automatic logic [31:0] sx16(input logic [15:0] x);
        sx16 = {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction

endpackage

// ===== hdl/pc_raw_if.sv =====
// Raw sample channel: valid/ready plus the 20-bit raw pressure.
// Depends on pc_pkg.
interface pc_raw_if;
    logic                     valid;
    logic                     ready;
    logic [pc_pkg::RAW_W-1:0] raw_pressure;
    modport source (output valid, output raw_pressure, input ready);
    modport sink   (input valid, input raw_pressure, output ready);
endinterface

// ===== hdl/pc_res_if.sv =====
// Result channel: valid/ready plus compensated pressure and its valid flag.
// Depends on pc_pkg.
interface pc_res_if;
    logic                      valid;
    logic                      ready;
    logic [pc_pkg::DATA_W-1:0] pressure_pa;
    logic                      valid_res;
    modport source (output valid, output pressure_pa, output valid_res, input ready);
    modport sink   (input valid, input pressure_pa, input valid_res, output ready);
endinterface

// ===== hdl/pc_cfg_if.sv =====
// Configuration write channel: valid/ready, register index, write data.
// Depends on pc_pkg.
interface pc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pc_pkg::ADDR_W-1:0] addr;
    logic [pc_pkg::DATA_W-1:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== hdl/pc_front.sv =====
// Front pipeline: calibration terms, divisor and dividend, four stages.
// Depends on pc_pkg.
module pc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pc_pkg::cal_t             cal,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [pc_pkg::RAW_W-1:0] in_raw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pc_pkg::div_in_t          out_data
);
    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic [pc_pkg::RAW_W-1:0] adc1_reg, adc2_reg;
    logic [31:0] t6_reg, t5_reg, t3_reg, t2_reg;
    logic [31:0] t6_next, t5_next, t3_next, t2_next;
    logic [31:0] v2a_reg, v1a_reg, v2a_next, v1a_next;
    logic [31:0] prod_reg, x_reg, prod_next, x_next;
    pc_pkg::div_in_t out_reg, out_next;
    logic [31:0] dv, pn;

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        t6_next = 32'(pc_pkg::sx16(cal.p6) * pc_pkg::K_QQ11);
        t5_next = 32'(pc_pkg::sx16(cal.p5) * pc_pkg::K_V1X2);
        t3_next = 32'(pc_pkg::sx16(cal.p3) * pc_pkg::K_QQ13);
        t2_next = 32'(pc_pkg::sx16(cal.p2) * pc_pkg::K_V1);

        v2a_next = 32'(pc_pkg::asr(32'(t6_reg + t5_reg), 2) + {cal.p4, 16'h0000});
        v1a_next = pc_pkg::asr(32'(pc_pkg::asr(t3_reg, 3) + pc_pkg::asr(t2_reg, 1)), 18);

        prod_next = 32'(32'(pc_pkg::K_HALF + v1a_reg) * {16'h0000, cal.p1});
        x_next    = 32'(32'(pc_pkg::K_FULL - {12'h000, adc2_reg}) - pc_pkg::asr(v2a_reg, 12));

        dv = pc_pkg::asr(prod_reg, 15);
        pn = 32'(x_reg * pc_pkg::K_3125);
        out_next.dv   = dv;
        out_next.dbl  = pn[31];
        out_next.num  = pn[31] ? pn : {pn[30:0], 1'b0};
        out_next.zero = (dv == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            adc1_reg <= in_raw;
            t6_reg   <= t6_next;
            t5_reg   <= t5_next;
            t3_reg   <= t3_next;
            t2_reg   <= t2_next;
        end
        if (rdy[1])
        begin
            adc2_reg <= adc1_reg;
            v2a_reg  <= v2a_next;
            v1a_reg  <= v1a_next;
        end
        if (rdy[2])
        begin
            prod_reg <= prod_next;
            x_reg    <= x_next;
        end
        if (rdy[3])
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = out_reg;

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.zero == (out_data.dv == 32'd0)))
        else $error("zero flag disagrees with divisor");

endmodule

// ===== hdl/pc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on pc_pkg.
module pc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pc_pkg::div_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pc_pkg::div_out_t out_data
);
    localparam int NST = 32;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [31:0] num_reg  [NST];
    logic [31:0] rem_reg  [NST];
    logic [31:0] dv_reg   [NST];
    logic        dbl_reg  [NST];
    logic        zero_reg [NST];

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic [31:0] num_src, rem_src, dv_src;
        logic        dbl_src, zero_src, vld_src;
        logic [32:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign num_src  = in_data.num;
            assign rem_src  = 32'd0;
            assign dv_src   = in_data.dv;
            assign dbl_src  = in_data.dbl;
            assign zero_src = in_data.zero;
            assign vld_src  = in_valid;
        end
        else
        begin : g_rest
            assign num_src  = num_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign dv_src   = dv_reg[k-1];
            assign dbl_src  = dbl_reg[k-1];
            assign zero_src = zero_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        assign trial = {rem_src, num_src[31]};
        assign ge    = (trial >= {1'b0, dv_src});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                num_reg[k]  <= {num_src[30:0], ge};
                rem_reg[k]  <= ge ? 32'(trial - {1'b0, dv_src}) : trial[31:0];
                dv_reg[k]   <= dv_src;
                dbl_reg[k]  <= dbl_src;
                zero_reg[k] <= zero_src;
            end
        end
    end

    assign in_ready      = rdy[0];
    assign out_valid     = vld_reg[NST-1];
    assign out_data.quo  = num_reg[NST-1];
    assign out_data.dbl  = dbl_reg[NST-1];
    assign out_data.zero = zero_reg[NST-1];

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dv_reg[NST-1] != 32'd0) |-> (rem_reg[NST-1] < dv_reg[NST-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== hdl/pc_back.sv =====
// Back pipeline: quadratic and linear corrections, four stages incl. output.
// Depends on pc_pkg.
module pc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pc_pkg::cal_t     cal,
    input  logic             in_valid,
    output logic             in_ready,
    input  pc_pkg::div_out_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_pressure,
    output logic             out_vres
);
    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic [31:0] p1_reg, p2_reg, p3_reg, p_next;
    logic        z1_reg, z2_reg, z3_reg;
    logic [31:0] sq_reg, t8_reg, sq_next, t8_next;
    logic [31:0] c9_reg, c8_reg, c9_next, c8_next;
    logic [31:0] res_reg, res_next;
    logic        vres_reg;

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        p_next   = in_data.dbl ? {in_data.quo[30:0], 1'b0} : in_data.quo;
        sq_next  = 32'({3'b000, p1_reg[31:3]} * {3'b000, p1_reg[31:3]});
        t8_next  = 32'({2'b00, p1_reg[31:2]} * pc_pkg::sx16(cal.p89[15:0]));
        c9_next  = pc_pkg::asr(32'(pc_pkg::sx16(cal.p89[31:16]) * {13'h0, sq_reg[31:13]}),
                               12);
        c8_next  = pc_pkg::asr(t8_reg, 13);
        res_next = 32'(p3_reg + pc_pkg::asr(32'(c9_reg + c8_reg + pc_pkg::sx16(cal.p7)), 4));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p1_reg <= p_next;
            z1_reg <= in_data.zero;
        end
        if (rdy[1])
        begin
            p2_reg <= p1_reg;
            z2_reg <= z1_reg;
            sq_reg <= sq_next;
            t8_reg <= t8_next;
        end
        if (rdy[2])
        begin
            p3_reg <= p2_reg;
            z3_reg <= z2_reg;
            c9_reg <= c9_next;
            c8_reg <= c8_next;
        end
        if (rdy[3])
        begin
            res_reg  <= z3_reg ? 32'd0 : res_next;
            vres_reg <= !z3_reg;
        end
    end

    assign in_ready     = rdy[0];
    assign out_valid    = vld_reg[NST-1];
    assign out_pressure = res_reg;
    assign out_vres     = vres_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_vres) |-> (out_pressure == 32'd0))
        else $error("invalid result carries nonzero pressure");

endmodule

// ===== hdl/pressure_compensation_int32.sv =====
// Pressure compensation core: from sample transfer to result a sample passes
// 4 front stages, 32 divider stages at one quotient bit each, and 4 back stages.
// Throughput one sample per cycle; every stage stalls only when its successor is full.
// Reset (rst_n low, async) empties the pipeline and clears all calibration
// registers to zero. Calibration writes complete in the cycle they are offered.
// Depends on pc_pkg, pc_raw_if, pc_res_if, pc_cfg_if, pc_front, pc_div, pc_back.
module pressure_compensation_int32 (
    input  logic     clk,
    input  logic     rst_n,
    pc_raw_if.sink   smp,
    pc_res_if.source res,
    pc_cfg_if.sink   cfg
);
    // Calibration words; words one to seven keep 16 bits, the packed pair 32.
    pc_pkg::cal_t cal_reg;

    logic            f_valid, f_ready;
    pc_pkg::div_in_t f_data;
    logic             d_valid, d_ready;
    pc_pkg::div_out_t d_data;

    // Config port never back-pressures; out-of-range indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                pc_pkg::CFG_P1:   cal_reg.p1  <= cfg.wdata[15:0];
                pc_pkg::CFG_P2:   cal_reg.p2  <= cfg.wdata[15:0];
                pc_pkg::CFG_P3:   cal_reg.p3  <= cfg.wdata[15:0];
                pc_pkg::CFG_P4:   cal_reg.p4  <= cfg.wdata[15:0];
                pc_pkg::CFG_P5:   cal_reg.p5  <= cfg.wdata[15:0];
                pc_pkg::CFG_P6:   cal_reg.p6  <= cfg.wdata[15:0];
                pc_pkg::CFG_P7:   cal_reg.p7  <= cfg.wdata[15:0];
                pc_pkg::CFG_P8P9: cal_reg.p89 <= cfg.wdata;
                default:          ;
            endcase
        end
    end

    // Front: fixed-temperature terms, divisor (v1) and scaled numerator.
    pc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (smp.valid),
        .in_ready  (smp.ready),
        .in_raw    (smp.raw_pressure),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // Unsigned 32/32 divide; doubling before or after is chosen by numerator bit 31.
    pc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    // Back: second-order correction; last stage is the output register.
    pc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cal          (cal_reg),
        .in_valid     (d_valid),
        .in_ready     (d_ready),
        .in_data      (d_data),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .out_pressure (res.pressure_pa),
        .out_vres     (res.valid_res)
    );

endmodule

// ===== dv/tb_pressure_compensation_int32.sv =====
// Testbench for the pressure compensation core: directed table, then random samples,
// checked in order against a predictor of the 32-bit integer compensation formula.
// Depends on pc_pkg, pc_raw_if, pc_res_if, pc_cfg_if and the core.
module tb_pressure_compensation_int32;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 40;

    typedef struct {
        logic [31:0] pa;
        logic        ok;
    } pa_result_t;

    // directed row: sample, plus optional typed-in expectation
    typedef struct {
        logic [19:0] raw;
        logic        fixed;
        logic [31:0] pa;
        logic        ok;
    } row_t;

    logic clk;
    logic rst_n;

    pc_raw_if smp ();
    pc_res_if res ();
    pc_cfg_if cfg ();

    pressure_compensation_int32 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp),
        .res   (res),
        .cfg   (cfg)
    );

    // predictor copy of the calibration registers
    logic [31:0] cal_regs [8];

    pa_result_t pa_expected [$];
    int         errors;
    int         cycles;
    bit         sink_idle_on;
    bit         long_hold;
    bit         src_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // arithmetic shift on 32-bit patterns
    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sext16(logic [31:0] x);
        return {{16{x[15]}}, x[15:0]};
    endfunction

    // compensated pressure from the current calibration set
    function automatic pa_result_t compensate(logic [19:0] raw);
        logic [31:0] p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] v1, v2, q, p, sq, num;
        pa_result_t  r;
        p2 = sext16(cal_regs[1]);
        p3 = sext16(cal_regs[2]);
        p4 = sext16(cal_regs[3]);
        p5 = sext16(cal_regs[4]);
        p6 = sext16(cal_regs[5]);
        p7 = sext16(cal_regs[6]);
        p8 = sext16(cal_regs[7]);
        p9 = sext16(cal_regs[7] >> 16);
        v1 = sra32(32'd100000, 1) - 32'd64000;
        q  = sra32(v1, 2);
        v2 = sra32(q * q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra32(v2, 2) + (p4 << 16);
        v1 = sra32(sra32(p3 * sra32(q * q, 13), 3) + sra32(p2 * v1, 1), 18);
        v1 = sra32((32'd32768 + v1) * cal_regs[0], 15);
        if (v1 == 32'd0)
        begin
            r.pa = '0;
            r.ok = 1'b0;
            return r;
        end
        num = ((32'd1048576 - 32'(raw)) - sra32(v2, 12)) * 32'd3125;
        // top bit of the numerator picks divide-then-double
        if (num[31] == 1'b0)
            p = (num << 1) / v1;
        else
            p = (num / v1) * 32'd2;
        sq = ((p >> 3) * (p >> 3)) >> 13;
        v1 = sra32(p9 * sq, 12);
        v2 = sra32((p >> 2) * p8, 13);
        r.pa = p + sra32(v1 + v2 + p7, 4);
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic write_cal(logic [7:0] idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.wdata <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx < 8)
            cal_regs[idx] = (idx == pc_pkg::CFG_P8P9) ? data : {16'd0, data[15:0]};
    endtask

    // idle between phases: drain, then wait out the pipeline
    task automatic drain();
        while (pa_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one sample transfer; optional fixed expectation replaces the prediction
    task automatic send_sample(logic [19:0] raw, logic fixed, pa_result_t want);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        smp.valid        <= 1'b1;
        smp.raw_pressure <= raw;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        pa_expected.push_back(fixed ? want : compensate(raw));
    endtask

    task automatic stop_sending();
        smp.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_cal();
        write_cal(pc_pkg::CFG_P1, $urandom_range(20000, 65535));
        write_cal(pc_pkg::CFG_P2, $urandom);
        write_cal(pc_pkg::CFG_P3, $urandom);
        write_cal(pc_pkg::CFG_P4, $urandom);
        write_cal(pc_pkg::CFG_P5, $urandom);
        write_cal(pc_pkg::CFG_P6, $urandom);
        write_cal(pc_pkg::CFG_P7, $urandom);
        write_cal(pc_pkg::CFG_P8P9, $urandom);
    endtask

    // result side: compare, with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (pa_expected.size() == 0)
            begin
                $display("unexpected transfer at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                pa_result_t w;
                w = pa_expected.pop_front();
                if (res.valid_res !== w.ok)
                    report_mismatch("valid_res", {31'd0, res.valid_res}, {31'd0, w.ok});
                if (res.pressure_pa !== w.pa)
                    report_mismatch("pressure_pa", res.pressure_pa, w.pa);
            end
        end
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold)
            res.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res.ready  <= (stall_left == 1);
        end
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 5);
            res.ready  <= 1'b0;
        end
        else
            res.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[pressure_compensation_int32] ERROR");
            $finish;
        end
    end

    row_t rows [$];

    initial
    begin
        pa_result_t none;
        int k;
        int n;
        errors = 0;
        sink_idle_on = 1'b0;
        long_hold = 1'b0;
        src_idle_on = 1'b0;
        smp.valid = 1'b0;
        smp.raw_pressure = '0;
        cfg.valid = 1'b0;
        cfg.addr = '0;
        cfg.wdata = '0;
        none.pa = '0;
        none.ok = 1'b0;
        for (int i = 0; i < 8; i++)
            cal_regs[i] = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset p1 is zero: divisor term zero, result flagged invalid
        rows = '{'{20'h00000, 1, 32'd0, 0}, '{20'hFFFFF, 1, 32'd0, 0},
                 '{20'h80000, 1, 32'd0, 0}};
        foreach (rows[i])
            send_sample(rows[i].raw, rows[i].fixed, '{rows[i].pa, rows[i].ok});
        stop_sending();
        drain();

        // typical calibration; extremes of raw and every raw bit
        write_cal(pc_pkg::CFG_P1, 32'd36477);
        write_cal(pc_pkg::CFG_P2, 32'hFFFF_D67D);
        write_cal(pc_pkg::CFG_P3, 32'd3024);
        write_cal(pc_pkg::CFG_P4, 32'd2855);
        write_cal(pc_pkg::CFG_P5, 32'd140);
        write_cal(pc_pkg::CFG_P6, 32'hFFFF_FFF9);
        write_cal(pc_pkg::CFG_P7, 32'd15500);
        write_cal(pc_pkg::CFG_P8P9, {16'd6000, 16'hD110});
        rows = '{'{20'h00000, 0, 0, 0}, '{20'hFFFFF, 0, 0, 0}, '{20'd415148, 0, 0, 0},
                 '{20'h55555, 0, 0, 0}, '{20'hAAAAA, 0, 0, 0}, '{20'h00001, 0, 0, 0}};
        foreach (rows[i])
            send_sample(rows[i].raw, rows[i].fixed, '{rows[i].pa, rows[i].ok});
        stop_sending();
        drain();

        // extreme calibration words, numerator with top bit set, negative divisor
        write_cal(pc_pkg::CFG_P1, 32'd65535);
        write_cal(pc_pkg::CFG_P2, 32'h0000_8000);
        write_cal(pc_pkg::CFG_P3, 32'h0000_8000);
        write_cal(pc_pkg::CFG_P4, 32'h0000_7FFF);
        write_cal(pc_pkg::CFG_P5, 32'h0000_8000);
        write_cal(pc_pkg::CFG_P6, 32'h0000_7FFF);
        write_cal(pc_pkg::CFG_P7, 32'h0000_8000);
        write_cal(pc_pkg::CFG_P8P9, 32'h8000_7FFF);
        write_cal(8'd200, 32'hFFFF_FFFF);  // out of range index: ignored
        for (int i = 0; i < 4; i++)
            send_sample(20'($urandom), 0, none);
        stop_sending();
        drain();
        write_cal(pc_pkg::CFG_P4, 32'h0000_8000);
        write_cal(pc_pkg::CFG_P2, 32'h0000_7FFF);
        write_cal(pc_pkg::CFG_P3, 32'h0000_7FFF);
        write_cal(pc_pkg::CFG_P8P9, 32'h7FFF_8000);
        for (int i = 0; i < 4; i++)
            send_sample(20'($urandom), 0, none);
        stop_sending();
        drain();

        // random phases, idling both sides
        sink_idle_on = 1'b1;
        src_idle_on = 1'b1;
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
                write_cal(pc_pkg::CFG_P1, 32'd1);  // near-zero divisor
            else
                random_cal();
            n = 100;
            for (k = 0; k < n; k++)
            begin
                if (ph == 1 && k == 20)
                begin
                    // long receiver hold-off while samples keep coming
                    fork
                        begin
                            long_hold = 1'b1;
                            repeat (120) @(posedge clk);
                            long_hold = 1'b0;
                        end
                    join_none
                end
                send_sample(20'($urandom), 0, none);
            end
            stop_sending();
            drain();
        end

        // last stretch with no idling
        sink_idle_on = 1'b0;
        src_idle_on = 1'b0;
        random_cal();
        for (k = 0; k < 40; k++)
            send_sample(20'($urandom), 0, none);
        stop_sending();
        drain();

        if (errors == 0)
            $display("[pressure_compensation_int32] OK");
        else
            $display("[pressure_compensation_int32] ERROR");
        $finish;
    end
endmodule
